### src/hbfc_pkg.sv
// hbfc_pkg: shared types, constants and the size merge helper for the heap free block
// used by hbfc_store, hbfc_ctrl and heap_block_free_coalesce
// no dependencies
`default_nettype none

package hbfc_pkg;

   localparam int unsigned HEAP_WORDS = 65536;
   localparam int unsigned IDX_W      = $clog2(HEAP_WORDS);
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [31:0] FREE_BIT   = 32'h8000_0000;
   localparam logic [31:0] SIZE_MASK  = 32'h00ff_ffff;
   localparam logic [31:0] HDR_BYTES  = 32'h0000_000c;
   localparam logic [31:0] OWNER_OFS  = 32'h0000_0008;
   localparam logic [31:0] LINK_OFS   = 32'h0000_0008;
   localparam logic [31:0] LOW_RESET  = 32'h007b_41a0;
   localparam logic [31:0] HIGH_RESET = 32'h00ab_4194;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_FREE  = 2'd2;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_IGNORED = 2'd1;
   localparam logic [1:0] STATUS_BACK    = 2'd2;
   localparam logic [1:0] STATUS_FWD     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_HIGH = CSR_IDX_W'(1);

   typedef struct packed {
      logic        en;
      logic        we;
      logic [31:0] addr;
      logic [31:0] wdata;
   } mem_req_type;

   typedef struct packed {
      logic [31:0] rdata;
      logic [31:0] owner;
      logic [1:0]  status;
   } rsp_beat_type;

   // add sizes in the low 24 bits, keep the flag bits of keep
   function automatic logic [31:0] size_merge(input logic [31:0] other,
                                              input logic [31:0] keep);
      logic [31:0] sum;
      sum = other + keep;
      return ((sum ^ keep) & SIZE_MASK) ^ keep;
   endfunction

endpackage

`default_nettype wire

### src/hbfc_store.sv
// hbfc_store: single port header word store with a registered read
// byte addresses outside the store read zero and drop writes; uses hbfc_pkg
`default_nettype none

module hbfc_store (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hbfc_pkg::mem_req_type mem_req,
   output logic [31:0]               mem_rdata
);

   logic [31:0]                store_mem [hbfc_pkg::HEAP_WORDS];
   logic [31:0]                rd_ff;
   logic                       hit_ff;
   logic                       hit_in;
   logic                       in_range;
   logic [hbfc_pkg::IDX_W-1:0] idx;

   assign in_range = mem_req.addr[31:2] < 30'(hbfc_pkg::HEAP_WORDS);
   assign idx      = mem_req.addr[hbfc_pkg::IDX_W+1:2];
   assign hit_in   = mem_req.en && !mem_req.we && in_range;

   always_ff @(posedge clock) begin
      if (mem_req.en && in_range) begin
         if (mem_req.we) begin
            store_mem[idx] <= mem_req.wdata;
         end else begin
            rd_ff <= store_mem[idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign mem_rdata = hit_ff ? rd_ff : 32'd0;

endmodule

`default_nettype wire

### src/hbfc_ctrl.sv
// hbfc_ctrl: request sequencer, host word access and free with coalescing
// drives hbfc_store at most one access per cycle; uses hbfc_pkg
`default_nettype none

module hbfc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_kind,
   input  wire logic [31:0]           req_addr,
   input  wire logic [31:0]           req_wdata,
   input  wire logic [31:0]           heap_low,
   input  wire logic [31:0]           heap_high,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output hbfc_pkg::rsp_beat_type     out_beat,
   output hbfc_pkg::mem_req_type      mem_req,
   input  wire logic [31:0]           mem_rdata
);

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_START    = 5'd1;
   localparam logic [4:0] ST_RDATA    = 5'd2;
   localparam logic [4:0] ST_OWN      = 5'd3;
   localparam logic [4:0] ST_HDR0     = 5'd4;
   localparam logic [4:0] ST_LINK_RD  = 5'd5;
   localparam logic [4:0] ST_PREV     = 5'd6;
   localparam logic [4:0] ST_PREV_HDR = 5'd7;
   localparam logic [4:0] ST_BSIZE    = 5'd8;
   localparam logic [4:0] ST_BHDR_RD  = 5'd9;
   localparam logic [4:0] ST_BHDR     = 5'd10;
   localparam logic [4:0] ST_BPH      = 5'd11;
   localparam logic [4:0] ST_FWD_RD   = 5'd12;
   localparam logic [4:0] ST_FWD_HDR  = 5'd13;
   localparam logic [4:0] ST_NEXT     = 5'd14;
   localparam logic [4:0] ST_RELINK   = 5'd15;
   localparam logic [4:0] ST_DONE     = 5'd16;

   logic [4:0]  state_ff,  state_in;
   logic [1:0]  kind_ff,   kind_in;
   logic [31:0] addr_ff,   addr_in;
   logic [31:0] wdata_ff,  wdata_in;
   logic [31:0] blk_ff,    blk_in;
   logic [31:0] prev_ff,   prev_in;
   logic [31:0] hdr_ff,    hdr_in;
   logic [31:0] rdata_ff,  rdata_in;
   logic [31:0] owner_ff,  owner_in;
   logic [1:0]  status_ff, status_in;

   logic [31:0] next_sum;
   logic [31:0] relink_sum;
   logic [31:0] relink_addr;
   logic [31:0] back_addr;
   logic [31:0] merged;

   assign next_sum    = (mem_rdata & hbfc_pkg::SIZE_MASK) + blk_ff;
   assign relink_sum  = (hdr_ff & hbfc_pkg::SIZE_MASK) + blk_ff;
   assign relink_addr = (hdr_ff & hbfc_pkg::SIZE_MASK) + blk_ff + hbfc_pkg::LINK_OFS;
   assign back_addr   = (mem_rdata & hbfc_pkg::SIZE_MASK) + blk_ff + hbfc_pkg::LINK_OFS;
   assign merged      = hbfc_pkg::size_merge(mem_rdata, hdr_ff);

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      addr_in   = addr_ff;
      wdata_in  = wdata_ff;
      blk_in    = blk_ff;
      prev_in   = prev_ff;
      hdr_in    = hdr_ff;
      rdata_in  = rdata_ff;
      owner_in  = owner_ff;
      status_in = status_ff;
      mem_req   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               addr_in   = req_addr;
               wdata_in  = req_wdata;
               rdata_in  = 32'd0;
               owner_in  = 32'd0;
               status_in = hbfc_pkg::STATUS_DONE;
               state_in  = ST_START;
            end
         end
         ST_START: begin
            unique case (kind_ff)
               hbfc_pkg::REQ_WRITE: begin
                  mem_req.en    = 1'b1;
                  mem_req.we    = 1'b1;
                  mem_req.addr  = addr_ff;
                  mem_req.wdata = wdata_ff;
                  state_in      = ST_DONE;
               end
               hbfc_pkg::REQ_READ: begin
                  mem_req.en   = 1'b1;
                  mem_req.addr = addr_ff;
                  state_in     = ST_RDATA;
               end
               hbfc_pkg::REQ_FREE: begin
                  if (addr_ff < heap_low || addr_ff > heap_high) begin
                     status_in = hbfc_pkg::STATUS_IGNORED;
                     state_in  = ST_DONE;
                  end else begin
                     mem_req.en   = 1'b1;
                     mem_req.addr = addr_ff - hbfc_pkg::OWNER_OFS;
                     blk_in       = addr_ff - hbfc_pkg::HDR_BYTES;
                     state_in     = ST_OWN;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_RDATA: begin
            rdata_in = mem_rdata;
            state_in = ST_DONE;
         end
         ST_OWN: begin
            owner_in     = mem_rdata;
            mem_req.en   = 1'b1;
            mem_req.addr = blk_ff;
            state_in     = ST_HDR0;
         end
         ST_HDR0: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = blk_ff;
            mem_req.wdata = mem_rdata | hbfc_pkg::FREE_BIT;
            state_in      = ST_LINK_RD;
         end
         ST_LINK_RD: begin
            mem_req.en   = 1'b1;
            mem_req.addr = blk_ff + hbfc_pkg::LINK_OFS;
            state_in     = ST_PREV;
         end
         ST_PREV: begin
            prev_in = mem_rdata;
            if (mem_rdata != blk_ff) begin
               mem_req.en   = 1'b1;
               mem_req.addr = mem_rdata;
               state_in     = ST_PREV_HDR;
            end else begin
               state_in = ST_FWD_RD;
            end
         end
         ST_PREV_HDR: begin
            if ((mem_rdata & hbfc_pkg::FREE_BIT) != 32'd0) begin
               mem_req.en   = 1'b1;
               mem_req.addr = blk_ff;
               state_in     = ST_BSIZE;
            end else begin
               state_in = ST_FWD_RD;
            end
         end
         ST_BSIZE: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = back_addr;
            mem_req.wdata = prev_ff;
            state_in      = ST_BHDR_RD;
         end
         ST_BHDR_RD: begin
            mem_req.en   = 1'b1;
            mem_req.addr = blk_ff;
            state_in     = ST_BHDR;
         end
         ST_BHDR: begin
            hdr_in       = mem_rdata;
            mem_req.en   = 1'b1;
            mem_req.addr = prev_ff;
            state_in     = ST_BPH;
         end
         ST_BPH: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = prev_ff;
            mem_req.wdata = hbfc_pkg::size_merge(hdr_ff, mem_rdata);
            blk_in        = prev_ff;
            status_in     = hbfc_pkg::STATUS_BACK;
            state_in      = ST_FWD_RD;
         end
         ST_FWD_RD: begin
            mem_req.en   = 1'b1;
            mem_req.addr = blk_ff;
            state_in     = ST_FWD_HDR;
         end
         ST_FWD_HDR: begin
            hdr_in = mem_rdata;
            if (next_sum < heap_high) begin
               mem_req.en   = 1'b1;
               mem_req.addr = next_sum;
               state_in     = ST_NEXT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_NEXT: begin
            if ((mem_rdata & hbfc_pkg::FREE_BIT) != 32'd0) begin
               mem_req.en    = 1'b1;
               mem_req.we    = 1'b1;
               mem_req.addr  = blk_ff;
               mem_req.wdata = merged;
               hdr_in        = merged;
               status_in     = hbfc_pkg::STATUS_FWD;
               state_in      = ST_RELINK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RELINK: begin
            if (relink_sum < heap_high) begin
               mem_req.en    = 1'b1;
               mem_req.we    = 1'b1;
               mem_req.addr  = relink_addr;
               mem_req.wdata = blk_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      addr_ff   <= addr_in;
      wdata_ff  <= wdata_in;
      blk_ff    <= blk_in;
      prev_ff   <= prev_in;
      hdr_ff    <= hdr_in;
      rdata_ff  <= rdata_in;
      owner_ff  <= owner_in;
      status_ff <= status_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign out_valid       = (state_ff == ST_DONE);
   assign out_beat.rdata  = rdata_ff;
   assign out_beat.owner  = owner_ff;
   assign out_beat.status = status_ff;

   a_idle_no_access: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_req.en)
      else $error("store access while idle");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_START)
      else $error("accepted beat did not start");

   a_handoff_idle: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_ready |=> state_ff == ST_IDLE)
      else $error("sequencer not idle after result handoff");

   a_ignored_empty: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_beat.status == hbfc_pkg::STATUS_IGNORED
      |-> out_beat.owner == 32'd0 && out_beat.rdata == 32'd0)
      else $error("ignored free carries data");

endmodule

`default_nettype wire

### src/heap_block_free_coalesce.sv
// heap_block_free_coalesce: top level, configuration registers and result register
// instantiates hbfc_ctrl and hbfc_store; uses hbfc_pkg
//
//  channel  ports                                    direction
//  req      req_valid/ready, req_type, addr, wdata   in
//  rsp      rsp_valid/ready, rdata, owner, status    out
//  csr      csr_valid/ready, csr_index, csr_wdata    in
//
// one item at a time through a single port store with a registered read
// write and read each make one store access, an out of range free none, and an in-window free
// a chain of dependent header reads and writes on the store port
// result register frees the sequencer while a beat waits on rsp_ready
// synchronous reset; store contents are not cleared, csr always ready
`default_nettype none

module heap_block_free_coalesce (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_type,
   input  wire logic [31:0]                    req_addr,
   input  wire logic [31:0]                    req_wdata,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [31:0]                         rsp_rdata,
   output logic [31:0]                         rsp_owner_clear_addr,
   output logic [1:0]                          rsp_status,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [hbfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                    csr_wdata
);

   logic [31:0]            heap_low_ff;
   logic [31:0]            heap_high_ff;
   logic                   rsp_valid_ff;
   hbfc_pkg::rsp_beat_type rsp_beat_ff;
   hbfc_pkg::rsp_beat_type out_beat;
   hbfc_pkg::mem_req_type  mem_req;
   logic [31:0]            mem_rdata;
   logic                   out_valid;
   logic                   out_ready;

   assign csr_ready = 1'b1;
   assign out_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_low_ff  <= hbfc_pkg::LOW_RESET;
         heap_high_ff <= hbfc_pkg::HIGH_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == hbfc_pkg::CSR_HEAP_LOW) begin
            heap_low_ff <= csr_wdata;
         end
         if (csr_index == hbfc_pkg::CSR_HEAP_HIGH) begin
            heap_high_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid && out_ready) begin
         rsp_beat_ff <= out_beat;
      end
   end

   hbfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_type),
      .req_addr  (req_addr),
      .req_wdata (req_wdata),
      .heap_low  (heap_low_ff),
      .heap_high (heap_high_ff),
      .out_valid (out_valid),
      .out_ready (out_ready),
      .out_beat  (out_beat),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   hbfc_store u_store (
      .clock     (clock),
      .reset     (reset),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_rdata            = rsp_beat_ff.rdata;
   assign rsp_owner_clear_addr = rsp_beat_ff.owner;
   assign rsp_status           = rsp_beat_ff.status;

endmodule

`default_nettype wire

### dv/heap_free_checker.sv
`timescale 1ns / 100ps
// heap_free_checker: watches the req, rsp and csr channels of heap_block_free_coalesce,
// keeps its own header store and window registers and checks every rsp beat in order
// depends on hbfc_pkg
`default_nettype none

module heap_free_checker
   import hbfc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic [1:0]           req_type,
   input  wire logic [31:0]          req_addr,
   input  wire logic [31:0]          req_wdata,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [31:0]          rsp_rdata,
   input  wire logic [31:0]          rsp_owner_clear_addr,
   input  wire logic [1:0]           rsp_status,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata,
   output int                        fail_count,
   output int                        owed_count
);

   logic [31:0]  header_copy [0:HEAP_WORDS-1];
   logic [31:0]  win_low;
   logic [31:0]  win_high;
   rsp_beat_type owed_beats [$];

   initial begin
      fail_count = 0;
      owed_count = 0;
   end

   function automatic logic [31:0] peek_header(input logic [31:0] byte_addr);
      if ((byte_addr >> 2) >= HEAP_WORDS) return 32'h0;
      return header_copy[byte_addr[IDX_W+1:2]];
   endfunction

   task automatic poke_header(input logic [31:0] byte_addr, input logic [31:0] val);
      if ((byte_addr >> 2) < HEAP_WORDS) header_copy[byte_addr[IDX_W+1:2]] = val;
   endtask

   // low 24 bits add up, upper flag bits come from keep
   function automatic logic [31:0] join_sizes(input logic [31:0] other,
                                              input logic [31:0] keep);
      return {keep[31:24], other[23:0] + keep[23:0]};
   endfunction

   task automatic serve_request(input logic [1:0] kind, input logic [31:0] a,
                                input logic [31:0] d, output rsp_beat_type beat);
      logic [31:0] blk;
      logic [31:0] prv;
      logic [31:0] hdr;
      logic [31:0] nxt;
      logic [31:0] merged;
      logic        back;
      logic        fwd;
      beat = '0;
      back = 1'b0;
      fwd  = 1'b0;
      case (kind)
         REQ_WRITE: poke_header(a, d);
         REQ_READ:  beat.rdata = peek_header(a);
         REQ_FREE: begin
            if (a < win_low || a > win_high) begin
               beat.status = STATUS_IGNORED;
            end else begin
               blk = a - HDR_BYTES;
               beat.owner = peek_header(a - OWNER_OFS);
               poke_header(blk, peek_header(blk) | FREE_BIT);
               prv = peek_header(blk + LINK_OFS);
               if (prv != blk && (peek_header(prv) & FREE_BIT) != 0) begin
                  poke_header(blk + (peek_header(blk) & SIZE_MASK) + LINK_OFS, prv);
                  hdr = peek_header(blk);
                  poke_header(prv, join_sizes(hdr, peek_header(prv)));
                  blk  = prv;
                  back = 1'b1;
               end
               hdr = peek_header(blk);
               nxt = (hdr & SIZE_MASK) + blk;
               if (nxt < win_high && (peek_header(nxt) & FREE_BIT) != 0) begin
                  merged = join_sizes(peek_header(nxt), hdr);
                  poke_header(blk, merged);
                  nxt = (merged & SIZE_MASK) + blk;
                  if (nxt < win_high) poke_header(nxt + LINK_OFS, blk);
                  fwd = 1'b1;
               end
               beat.status = fwd ? STATUS_FWD : (back ? STATUS_BACK : STATUS_DONE);
            end
         end
         default: beat = '0;
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (fail_count < 100)
         $display("%0t checker: %s expected %h got %h", $time, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      rsp_beat_type due;
      if (reset) begin
         win_low  = LOW_RESET;
         win_high = HIGH_RESET;
         owed_beats.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HEAP_LOW) win_low = csr_wdata;
            else if (csr_index == CSR_HEAP_HIGH) win_high = csr_wdata;
         end
         if (req_valid && req_ready) begin
            serve_request(req_type, req_addr, req_wdata, due);
            owed_beats.push_back(due);
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_beats.size() == 0) begin
               report_mismatch("rsp beat with nothing owed, rdata", 32'h0, rsp_rdata);
            end else begin
               due = owed_beats.pop_front();
               if (rsp_rdata !== due.rdata)
                  report_mismatch("rdata", due.rdata, rsp_rdata);
               if (rsp_owner_clear_addr !== due.owner)
                  report_mismatch("owner_clear_addr", due.owner, rsp_owner_clear_addr);
               if (rsp_status !== due.status)
                  report_mismatch("status", 32'(due.status), 32'(rsp_status));
            end
         end
      end
      owed_count <= owed_beats.size();
   end

endmodule

`default_nettype wire

### dv/heap_block_free_coalesce_tb.sv
`timescale 1ns / 100ps
// heap_block_free_coalesce_tb: clock, reset, stimulus and verdict for heap_block_free_coalesce
// loads a low region of the header store, then directed and random heap traffic under windows
// depends on hbfc_pkg, heap_free_checker and the block
`default_nettype none

module heap_block_free_coalesce_tb;
   import hbfc_pkg::*;

   localparam int                   IDLE_PCT    = 38;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE   = CSR_IDX_W'(3);
   localparam logic [1:0]           REQ_SPARE   = 2'd3;
   localparam logic [31:0]          STORE_BYTES = 32'(HEAP_WORDS * 4);
   localparam int                   RGN_WORDS   = 256;
   localparam logic [31:0]          RGN_BYTES   = 32'(RGN_WORDS * 4);

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic [1:0]           req_type  = REQ_WRITE;
   logic [31:0]          req_addr  = '0;
   logic [31:0]          req_wdata = '0;
   logic                 rsp_ready = 1'b0;
   logic                 csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_HEAP_LOW;
   logic [31:0]          csr_wdata = '0;
   wire logic            req_ready;
   wire logic            rsp_valid;
   wire logic [31:0]     rsp_rdata;
   wire logic [31:0]     rsp_owner_clear_addr;
   wire logic [1:0]      rsp_status;
   wire logic            csr_ready;
   int                   fail_count;
   int                   owed_count;

   bit req_gappy  = 1'b0;
   bit rsp_gappy  = 1'b0;
   int beats_sent = 0;

   heap_block_free_coalesce u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_type             (req_type),
      .req_addr             (req_addr),
      .req_wdata            (req_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_rdata            (rsp_rdata),
      .rsp_owner_clear_addr (rsp_owner_clear_addr),
      .rsp_status           (rsp_status),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   heap_free_checker u_heap_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_type             (req_type),
      .req_addr             (req_addr),
      .req_wdata            (req_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_rdata            (rsp_rdata),
      .rsp_owner_clear_addr (rsp_owner_clear_addr),
      .rsp_status           (rsp_status),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .fail_count           (fail_count),
      .owed_count           (owed_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= !rsp_gappy || $urandom_range(99) >= IDLE_PCT;
   end

   // a stored word taken as an address lands in the loaded region or beyond the store
   function automatic logic [31:0] safe_word(input logic [31:0] v);
      if (v >= RGN_BYTES && v < STORE_BYTES) return v | 32'h0100_0000;
      return v;
   endfunction

   // valid stays high between back-to-back beats
   task automatic send_beat(input logic [1:0] kind, input logic [31:0] a,
                            input logic [31:0] d);
      while (req_gappy && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= kind;
      req_addr  <= a;
      req_wdata <= d;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_window(input logic [31:0] lo, input logic [31:0] hi);
      csr_beat(CSR_HEAP_LOW, lo);
      csr_beat(CSR_HEAP_HIGH, hi);
      csr_beat(CSR_SPARE, $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_size(input bit tidy);
      if (tidy) return $urandom_range(16, 3) << 2;
      case ($urandom_range(9))
         0:       return $urandom & SIZE_MASK;
         1:       return $urandom_range(64, 12);
         default: return $urandom_range(16, 3) << 2;
      endcase
   endfunction

   // three neighbouring blocks, free the middle one, read back the headers
   task automatic build_and_free(input bit prev_free, input bit next_free, input bit tidy);
      logic [31:0] pb;
      logic [31:0] bb;
      logic [31:0] nb;
      logic [31:0] fb;
      logic [31:0] sp;
      logic [31:0] sb;
      logic [31:0] sn;
      logic [31:0] link;
      logic [31:0] ptr;
      int          pick;
      sp   = pick_size(tidy);
      sb   = pick_size(tidy);
      sn   = pick_size(tidy);
      pb   = $urandom_range(RGN_BYTES - 256) & ~32'h3;
      bb   = pb + sp;
      nb   = bb + sb;
      fb   = nb + sn;
      pick = tidy ? 0 : $urandom_range(9);
      link = (pick < 7) ? pb : (pick < 8) ? bb : $urandom_range(1) ? safe_word($urandom) :
             $urandom_range(RGN_BYTES - 1);
      ptr  = bb + HDR_BYTES;
      if (!tidy && $urandom_range(7) == 0) ptr = ptr + $urandom_range(3, 1);
      send_beat(REQ_WRITE, pb, safe_word({prev_free, 7'($urandom), sp[23:0]}));
      send_beat(REQ_WRITE, bb,
                safe_word({!tidy && $urandom_range(7) == 0, 7'($urandom), sb[23:0]}));
      send_beat(REQ_WRITE, bb + OWNER_OFS - 4, $urandom_range(1) ? safe_word($urandom) : 32'h0);
      send_beat(REQ_WRITE, bb + LINK_OFS, link);
      send_beat(REQ_WRITE, nb, safe_word({next_free, 7'($urandom), sn[23:0]}));
      send_beat(REQ_FREE, ptr, $urandom);
      send_beat(REQ_READ, pb, $urandom);
      send_beat(REQ_READ, bb, $urandom);
      send_beat(REQ_READ, nb, $urandom);
      send_beat(REQ_READ, (fb + LINK_OFS < RGN_BYTES) ? fb + LINK_OFS : nb, $urandom);
   endtask

   task automatic random_beat();
      logic [31:0] a;
      a = ($urandom_range(1) == 0) ? $urandom_range(STORE_BYTES, 32'hffff_ffff) :
          $urandom_range(RGN_BYTES - 1);
      send_beat(2'($urandom_range(3)), a, safe_word($urandom));
   endtask

   task automatic random_phase(input int quota);
      int stop;
      stop = beats_sent + quota;
      while (beats_sent < stop) begin
         if ($urandom_range(99) < 70)
            build_and_free($urandom_range(1), $urandom_range(1), 1'b0);
         else
            random_beat();
      end
   endtask

   initial begin
      logic [31:0] lo;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // low region written once, every random read stays inside it or beyond the store
      for (int w = 0; w < RGN_WORDS; w++) send_beat(REQ_WRITE, 32'(w) << 2, safe_word($urandom));
      req_gappy <= 1'b1;
      rsp_gappy <= 1'b1;

      send_beat(REQ_WRITE, 32'hffff_fffc, 32'hffff_ffff);
      send_beat(REQ_READ, 32'hffff_fffc, 32'h0);
      send_beat(REQ_WRITE, STORE_BYTES - 4, 32'h5a5a_a5a5);
      send_beat(REQ_READ, STORE_BYTES - 1, 32'hffff_ffff);
      send_beat(REQ_READ, STORE_BYTES, 32'h0);
      send_beat(REQ_WRITE, 32'h2, 32'h10);
      send_beat(REQ_SPARE, 32'hffff_ffff, 32'hffff_ffff);
      send_beat(REQ_FREE, LOW_RESET - 1, 32'h0);
      send_beat(REQ_FREE, HIGH_RESET + 1, 32'h0);
      send_beat(REQ_FREE, LOW_RESET, 32'h0);
      send_beat(REQ_FREE, HIGH_RESET, 32'h0);
      settle();

      program_window(32'h0, 32'hffff_ffff);
      send_beat(REQ_FREE, 32'h0, 32'h0);
      send_beat(REQ_FREE, 32'hffff_ffff, 32'hffff_ffff);
      build_and_free(1'b1, 1'b1, 1'b1);
      settle();

      // inverted window, every free ignored
      program_window(32'hffff_ffff, 32'h0);
      random_phase(150);
      settle();

      program_window(32'h10, RGN_BYTES);
      random_phase(350);
      settle();

      lo = $urandom_range(RGN_BYTES / 2);
      program_window(lo, $urandom_range(RGN_BYTES, lo));
      req_gappy <= 1'b0;
      random_phase(350);
      settle();

      if (fail_count == 0 && owed_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
